FILE: rtl/core/ssc_pkg.sv
// ----------------------------------------------------------------------------
// Staggered seven-segment counters: shared definitions
// Digit count, field widths, register indexes and the segment code table.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

  // Number of digits in the display chain.
  localparam int unsigned DIGITS = 9;

  // Field widths.
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned BASE_W   = 16;
  localparam int unsigned STEP_W   = 12;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned PAT_W    = 8;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned REG_IDX_W = 1;

  // The largest period is base plus eight steps, which fits in 17 bits.
  localparam int unsigned PERIOD_W = 17;

  // Register indexes of the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_BASE_PERIOD = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_PERIOD_STEP = 1'd1;

  // Register reset values.
  localparam logic [BASE_W-1:0] BASE_RESET = 16'd500;
  localparam logic [STEP_W-1:0] STEP_RESET = 12'd100;

  // Highest decimal count; the counter wraps back to zero after it.
  localparam logic [CNT_W-1:0] COUNT_MAX = 4'd9;

  // Reset patterns repeat the codes of 1 to 9 along the chain.
  localparam int unsigned RESET_CYCLE = 9;

  // Segment byte (dp g f e d c b a) for a decimal count.
  function automatic logic [PAT_W-1:0] seg_code(input logic [CNT_W-1:0] count);
    logic [PAT_W-1:0] code;
    unique case (count)
      4'd0:    code = 8'b0011_1111;
      4'd1:    code = 8'b0000_0110;
      4'd2:    code = 8'b0101_1011;
      4'd3:    code = 8'b0100_1111;
      4'd4:    code = 8'b0110_0110;
      4'd5:    code = 8'b0110_1101;
      4'd6:    code = 8'b0111_1101;
      4'd7:    code = 8'b0000_0111;
      4'd8:    code = 8'b0111_1111;
      4'd9:    code = 8'b0110_1111;
      default: code = 8'b0011_1111;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/staggered_seven_segment_counters_unit.sv
// A request is scanned one digit per cycle once it has been accepted;
// the first byte of a frame is offered on the cycle after the scan ends.
// A new request is accepted only when the unit is idle again: after the scan if no
// digit changed, else once the receiver has taken the last byte of the frame.
// The digit rings rotate once per scanned digit and once per delivered byte.
// Reset clears all counts and times and loads the codes of 1 to 9; no clearing pass.
// ----------------------------------------------------------------------------
// Staggered seven-segment counters unit
// Keeps a time stamp, a decimal count and a shown pattern per digit in
// rotating shift registers, updates the digits that are due and sends the
// whole pattern chain as one frame of bytes when any digit changed.
// ----------------------------------------------------------------------------
`default_nettype none

module staggered_seven_segment_counters_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [ssc_pkg::REG_IDX_W-1:0]       cfg_addr_i,
  input  wire logic [ssc_pkg::CFG_W-1:0]           cfg_wdata_i,
  // Time request channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [ssc_pkg::TIME_W-1:0]          now_ms_i,
  // Pattern byte channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [ssc_pkg::PAT_W-1:0]                pattern_o,
  output logic [ssc_pkg::POS_W-1:0]                position_o,
  output logic                                     last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SEND
  } state_e;

  localparam logic [ssc_pkg::POS_W-1:0] LAST_POS = ssc_pkg::POS_W'(ssc_pkg::DIGITS - 1);

  state_e                              state_q;
  logic [ssc_pkg::POS_W-1:0]           idx_q;
  logic                                any_q;
  logic [ssc_pkg::TIME_W-1:0]          now_q;
  logic [ssc_pkg::PERIOD_W-1:0]        period_q;
  logic [ssc_pkg::BASE_W-1:0]          base_q;
  logic [ssc_pkg::STEP_W-1:0]          step_q;

  // Digit rings: entry 0 is the digit being worked on.
  logic [ssc_pkg::TIME_W-1:0]          lc_q  [ssc_pkg::DIGITS];
  logic [ssc_pkg::CNT_W-1:0]           cnt_q [ssc_pkg::DIGITS];
  logic [ssc_pkg::PAT_W-1:0]           pat_q [ssc_pkg::DIGITS];

  logic                                in_acc;
  logic                                out_acc;
  logic [ssc_pkg::TIME_W-1:0]          elapsed;
  logic                                due;
  logic [ssc_pkg::CNT_W-1:0]           cnt_clamp;
  logic [ssc_pkg::CNT_W-1:0]           cnt_next;
  logic [ssc_pkg::TIME_W-1:0]          head_lc_d;
  logic [ssc_pkg::CNT_W-1:0]           head_cnt_d;
  logic [ssc_pkg::PAT_W-1:0]           head_pat_d;
  logic                                rotate;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Due check and update of the head digit.
  always_comb begin
    elapsed    = now_q - lc_q[0];
    due        = elapsed >= ssc_pkg::TIME_W'(period_q);
    cnt_clamp  = (cnt_q[0] > ssc_pkg::COUNT_MAX) ? '0 : cnt_q[0];
    cnt_next   = (cnt_clamp == ssc_pkg::COUNT_MAX) ? '0 : cnt_clamp + 1'b1;
    head_lc_d  = lc_q[0];
    head_cnt_d = cnt_q[0];
    head_pat_d = pat_q[0];
    if (state_q == ST_SCAN && due) begin
      head_lc_d  = now_q;
      head_cnt_d = cnt_next;
      head_pat_d = ssc_pkg::seg_code(cnt_clamp);
    end
  end

  // The rings advance once per scanned digit and once per delivered byte.
  assign rotate = (state_q == ST_SCAN) || out_acc;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= ssc_pkg::BASE_RESET;
      step_q <= ssc_pkg::STEP_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        ssc_pkg::REG_BASE_PERIOD: base_q <= cfg_wdata_i[ssc_pkg::BASE_W-1:0];
        ssc_pkg::REG_PERIOD_STEP: step_q <= cfg_wdata_i[ssc_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Digit rings.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ssc_pkg::DIGITS; k++) begin
        lc_q[k]  <= '0;
        cnt_q[k] <= '0;
        pat_q[k] <= ssc_pkg::seg_code(ssc_pkg::CNT_W'((k % ssc_pkg::RESET_CYCLE) + 1));
      end
    end else if (rotate) begin
      for (int k = 0; k < ssc_pkg::DIGITS - 1; k++) begin
        lc_q[k]  <= lc_q[k+1];
        cnt_q[k] <= cnt_q[k+1];
        pat_q[k] <= pat_q[k+1];
      end
      lc_q[ssc_pkg::DIGITS-1]  <= head_lc_d;
      cnt_q[ssc_pkg::DIGITS-1] <= head_cnt_d;
      pat_q[ssc_pkg::DIGITS-1] <= head_pat_d;
    end
  end

  // Sequencer: accept a time, scan the digits, then send the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      idx_q    <= '0;
      any_q    <= 1'b0;
      now_q    <= '0;
      period_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q  <= ST_SCAN;
            idx_q    <= '0;
            any_q    <= 1'b0;
            now_q    <= now_ms_i;
            period_q <= ssc_pkg::PERIOD_W'(base_q);
          end
        end
        ST_SCAN: begin
          period_q <= period_q + ssc_pkg::PERIOD_W'(step_q);
          if (idx_q == LAST_POS) begin
            idx_q   <= '0;
            state_q <= (any_q || due) ? ST_SEND : ST_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
            any_q <= any_q || due;
          end
        end
        ST_SEND: begin
          if (out_acc) begin
            if (idx_q == LAST_POS) begin
              idx_q   <= '0;
              state_q <= ST_IDLE;
            end else begin
              idx_q <= idx_q + 1'b1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_SEND);
  assign pattern_o   = pat_q[0];
  assign position_o  = idx_q;
  assign last_o      = (idx_q == LAST_POS);

  // A frame never overlaps the acceptance of a new request.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("request channel ready while a frame is pending");

  // A request is always scanned before any byte is offered.
  a_scan_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !out_valid_o)
    else $error("byte offered right after request acceptance");

  // Bytes of a frame come in order of position.
  a_pos_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !last_o) |=> (out_valid_o && position_o == $past(position_o) + 1'b1))
    else $error("frame byte positions out of order");

  // After the final byte the unit is ready for the next request.
  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_o) |=> in_ready_o)
    else $error("unit not ready after frame end");

endmodule

`default_nettype wire

FILE: tb/chain_frame_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pattern chain checker
// Watches the register port and both channels of the counter unit, keeps its
// own copy of the digit times, counts and shown patterns, and compares every
// pattern byte with the frame it predicts for each accepted time request.
// ----------------------------------------------------------------------------
`default_nettype none

module chain_frame_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [ssc_pkg::REG_IDX_W-1:0] cfg_addr_i,
  input  wire logic [ssc_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  wire logic                          in_valid_i,
  input  wire logic                          in_ready_i,
  input  wire logic [ssc_pkg::TIME_W-1:0]    now_ms_i,
  input  wire logic                          out_valid_i,
  input  wire logic                          out_ready_i,
  input  wire logic [ssc_pkg::PAT_W-1:0]     pattern_i,
  input  wire logic [ssc_pkg::POS_W-1:0]     position_i,
  input  wire logic                          last_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 requests_o,
  output int                                 frames_o,
  output int                                 bytes_o
);

  import ssc_pkg::*;

  typedef struct packed {
    logic [PAT_W-1:0] pattern;
    logic [POS_W-1:0] position;
    logic             last;
  } chain_byte_t;

  // Segment bytes for the counts 0 to 9, highest count first.
  localparam logic [9:0][PAT_W-1:0] DIGIT_SEGMENTS = {
    8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
  };

  localparam int REPORT_LIMIT = 10;

  // Predicted display state and register copies.
  logic [BASE_W-1:0] base_period_q;
  logic [STEP_W-1:0] period_step_q;
  logic [TIME_W-1:0] change_stamp [DIGITS];
  logic [CNT_W-1:0]  decimal_count [DIGITS];
  logic [PAT_W-1:0]  lit_pattern [DIGITS];

  chain_byte_t chain_bytes_due [$];
  int          mismatches;
  int          requests_seen;
  int          frames_seen;
  int          bytes_seen;

  // Advance every digit that is due at this time and queue the frame if any changed.
  task automatic predict_frame(input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] base32;
    logic [TIME_W-1:0] step32;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] elapsed;
    chain_byte_t       entry;
    bit                changed;
    int                d;
    base32  = base_period_q;
    step32  = period_step_q;
    changed = 1'b0;
    for (d = 0; d < DIGITS; d++) begin
      period  = base32 + step32 * d;
      elapsed = now - change_stamp[d];
      if (elapsed >= period) begin
        change_stamp[d] = now;
        lit_pattern[d]  = DIGIT_SEGMENTS[decimal_count[d]];
        if (decimal_count[d] >= COUNT_MAX) begin
          decimal_count[d] = '0;
        end else begin
          decimal_count[d] = decimal_count[d] + 1'b1;
        end
        changed = 1'b1;
      end
    end
    if (changed) begin
      for (d = 0; d < DIGITS; d++) begin
        entry.pattern  = lit_pattern[d];
        entry.position = POS_W'(d);
        entry.last     = (d == DIGITS - 1);
        chain_bytes_due.push_back(entry);
      end
    end
  endtask

  // Record one failure, with details for the first few.
  task automatic note_failure(input string what, input chain_byte_t want, input chain_byte_t got);
    if (mismatches < REPORT_LIMIT) begin
      $display("%0t: %s: expected pattern %02h position %0d last %0b, got pattern %02h position %0d last %0b",
               $realtime, what, want.pattern, want.position, want.last,
               got.pattern, got.position, got.last);
    end
    mismatches++;
  endtask

  // Prediction and comparison on every clock edge.
  always @(posedge clk_i or negedge rst_ni) begin
    chain_byte_t got;
    chain_byte_t want;
    int d;
    if (!rst_ni) begin
      base_period_q = BASE_RESET;
      period_step_q = STEP_RESET;
      for (d = 0; d < DIGITS; d++) begin
        change_stamp[d]  = '0;
        decimal_count[d] = '0;
        lit_pattern[d]   = DIGIT_SEGMENTS[(d % RESET_CYCLE) + 1];
      end
      chain_bytes_due.delete();
      mismatches    = 0;
      requests_seen = 0;
      frames_seen   = 0;
      bytes_seen    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_BASE_PERIOD: base_period_q = cfg_wdata_i[BASE_W-1:0];
          REG_PERIOD_STEP: period_step_q = cfg_wdata_i[STEP_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        requests_seen++;
        predict_frame(now_ms_i);
      end
      if (out_valid_i && out_ready_i) begin
        got.pattern  = pattern_i;
        got.position = position_i;
        got.last     = last_i;
        bytes_seen++;
        if (last_i) begin
          frames_seen++;
        end
        if (chain_bytes_due.size() == 0) begin
          want = '0;
          note_failure("byte with no frame pending", want, got);
        end else begin
          want = chain_bytes_due.pop_front();
          if (got !== want) begin
            note_failure("pattern byte mismatch", want, got);
          end
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= chain_bytes_due.size();
    requests_o   <= requests_seen;
    frames_o     <= frames_seen;
    bytes_o      <= bytes_seen;
  end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Staggered seven-segment counters testbench
// Drives millisecond time requests and register settings into the counter
// unit under changing idle patterns and one long output hold-off; a checker
// beside the unit predicts and compares every pattern frame.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  import ssc_pkg::*;

  localparam int  CLK_HALF_NS  = 10;
  localparam int  RESET_CYCLES = 7;
  localparam int  SETTLE_EDGES = 40;
  localparam int  HOLD_CYCLES  = 400;
  localparam int  PHASES       = 6;
  localparam int  PHASE_ITEMS  = 45;
  localparam int  HOLD_AT_ITEM = 200;
  localparam real LIMIT_NS     = 5_000_000.0;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_addr_i  = REG_BASE_PERIOD;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  logic [TIME_W-1:0]    now_ms_i    = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [PAT_W-1:0]     pattern_o;
  logic [POS_W-1:0]     position_o;
  logic                 last_o;

  int fail_count;
  int pending;
  int requests;
  int frames;
  int bytes_checked;

  int tx_idle_pct  = 16;
  int rx_idle_pct  = 85;
  logic rx_hold      = 1'b0;
  logic hold_trigger = 1'b0;

  // Time base and register values the stimulus works from.
  logic [TIME_W-1:0] clock_ms = '0;
  logic [BASE_W-1:0] cur_base = BASE_RESET;
  logic [STEP_W-1:0] cur_step = STEP_RESET;

  staggered_seven_segment_counters_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .now_ms_i    (now_ms_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pattern_o   (pattern_o),
    .position_o  (position_o),
    .last_o      (last_o)
  );

  chain_frame_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .now_ms_i     (now_ms_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pattern_i    (pattern_o),
    .position_i   (position_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .requests_o   (requests),
    .frames_o     (frames),
    .bytes_o      (bytes_checked)
  );

  // Free-running clock.
  initial begin
    forever begin
      #(CLK_HALF_NS) clk_i = ~clk_i;
    end
  end

  // Receiver readiness, random unless a hold-off is running.
  always @(posedge clk_i) begin
    if (rx_hold) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // One long receiver hold-off so the unit holds its frame and stalls its input.
  initial begin
    wait (hold_trigger);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Run limit.
  initial begin
    #(LIMIT_NS);
    $display("testbench failed");
    $finish;
  end

  // Offer one time request; valid stays high afterwards unless a gap follows.
  task automatic offer_time(input logic [TIME_W-1:0] t);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    now_ms_i   <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    clock_ms = t;
  endtask

  // Stop offering and wait until every frame is out and the scan has finished.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_EDGES) @(posedge clk_i);
  endtask

  // Write both registers while the unit is idle.
  task automatic apply_setting(input logic [CFG_W-1:0] base_data,
                               input logic [CFG_W-1:0] step_data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_BASE_PERIOD;
    cfg_wdata_i <= base_data;
    @(posedge clk_i);
    cfg_addr_i  <= REG_PERIOD_STEP;
    cfg_wdata_i <= step_data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_base = base_data[BASE_W-1:0];
    cur_step = step_data[STEP_W-1:0];
  endtask

  // Next random time: mostly forward steps around the digit periods, with
  // repeats, backward steps and arbitrary jumps mixed in.
  function automatic logic [TIME_W-1:0] next_time();
    logic [TIME_W-1:0] span;
    int unsigned       pick;
    span = cur_base + cur_step * (DIGITS - 1);
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      return clock_ms + $urandom_range(0, span + span / 2 + 1);
    end else if (pick < 75) begin
      return clock_ms;
    end else if (pick < 87) begin
      return clock_ms - $urandom_range(1, span + 1);
    end
    return $urandom;
  endfunction

  // Stimulus and verdict.
  initial begin
    logic [CFG_W-1:0] base_data;
    logic [CFG_W-1:0] step_data;
    int               phase;
    int               n;
    int               k;
    int               sent;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: nothing due, digit 0 just short of due and then due, all due,
    // time going backwards, the top of the time range and a wrap back to zero.
    offer_time(32'd0);
    offer_time(32'd499);
    offer_time(32'd500);
    offer_time(32'd1300);
    offer_time(32'd1299);
    offer_time(32'hFFFF_FFFF);
    offer_time(32'd0);
    settle();

    // Zero periods: every request changes every digit, so the counts wrap.
    apply_setting(16'd0, 16'd0);
    offer_time(32'hAAAA_AAAA);
    offer_time(32'h5555_5555);
    for (k = 0; k < 9; k++) begin
      offer_time(clock_ms);
    end
    settle();

    // Largest periods, with the step write carrying bits beyond its width.
    apply_setting(16'hFFFF, 16'hFFFF);
    offer_time(clock_ms + 32'd65534);
    offer_time(clock_ms + 32'd1);
    offer_time(clock_ms + 32'd32760);
    settle();

    // Random part over several register settings and idle patterns.
    sent = 0;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin base_data = 16'd1;    step_data = 16'd0;    end
        1: begin base_data = 16'd0;    step_data = 16'hAFFF; end
        2: begin base_data = 16'hFFFF; step_data = 16'hFFFF; end
        3: begin
          base_data = CFG_W'($urandom_range(1, 400));
          step_data = CFG_W'($urandom_range(0, 60));
        end
        4: begin
          base_data = CFG_W'($urandom);
          step_data = CFG_W'($urandom);
        end
        default: begin base_data = BASE_RESET; step_data = STEP_RESET; end
      endcase
      apply_setting(base_data, step_data);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (sent == 90) begin
          tx_idle_pct <= 85;
          rx_idle_pct <= 16;
        end else if (sent == 180) begin
          tx_idle_pct <= 0;
          rx_idle_pct <= 0;
        end
        if (sent == HOLD_AT_ITEM) begin
          hold_trigger <= 1'b1;
        end
        offer_time(next_time());
        sent++;
      end
      settle();
    end

    $display("Checked %0d time requests over nine register settings: %0d frames, %0d bytes.",
             requests, frames, bytes_checked);
    $display("Idle patterns: sender light and receiver heavy, the reverse, none, one %0d-cycle hold-off.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: staggered_seven_segment_counters_unit.f
rtl/core/ssc_pkg.sv
rtl/core/staggered_seven_segment_counters_unit.sv
tb/chain_frame_checker.sv
tb/testbench.sv
